/* hdl/bbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants for the blob centroid block: field widths, register
// indexes, reset values and default frame limits.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int PIXEL_W     = 8;
  localparam int COORD_W     = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [PIXEL_W-1:0] BACKGROUND = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Frames in flight between the accumulator and the divider.
  localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

/* hdl/bbc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_front
// Pixel side: holds frame size registers, tracks raster position, sums hit
// coordinates and pushes one request of totals per finished frame.
// ----------------------------------------------------------------------------
module bbc_front #(
  parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT),
  parameter int HIT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  parameter int SUM_W      = ((COL_W > ROW_W) ? COL_W : ROW_W) + HIT_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bbc_pkg::PIXEL_W-1:0]       pixel_value,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output logic [2*SUM_W+HIT_W-1:0]               q_data
);

  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  logic [bbc_pkg::CFG_W-1:0] frame_width;
  logic [bbc_pkg::CFG_W-1:0] frame_height;
  logic [COL_W-1:0]          column_count;
  logic [ROW_W-1:0]          row_count;
  logic [SUM_W-1:0]          column_sum;
  logic [SUM_W-1:0]          row_sum;
  logic [HIT_W-1:0]          hit_count;

  logic [SUM_W-1:0] column_sum_next;
  logic [SUM_W-1:0] row_sum_next;
  logic [HIT_W-1:0] hit_count_next;
  logic [WID_W-1:0] eff_width;
  logic [HGT_W-1:0] eff_height;
  logic             is_hit;
  logic             accept;
  logic             row_end;
  logic             frame_end;

  // Zero acts as one; oversize saturates to the limit.
  function automatic int clamp_size(input logic [bbc_pkg::CFG_W-1:0] v, input int maxv);
    int r;
    r = int'(v);
    if (v == '0) r = 1;
    else if (r > maxv) r = maxv;
    return r;
  endfunction

  always_comb begin
    eff_width       = WID_W'(clamp_size(frame_width, MAX_WIDTH));
    eff_height      = HGT_W'(clamp_size(frame_height, MAX_HEIGHT));
    is_hit          = (pixel_value != bbc_pkg::BACKGROUND);
    column_sum_next = column_sum + (is_hit ? SUM_W'(column_count) : '0);
    row_sum_next    = row_sum + (is_hit ? SUM_W'(row_count) : '0);
    hit_count_next  = hit_count + (is_hit ? HIT_W'(1) : '0);
    row_end         = !((32'(column_count) + 32'd1) < 32'(eff_width));
    frame_end       = row_end && !((32'(row_count) + 32'd1) < 32'(eff_height));
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && frame_end;
  assign q_data   = {column_sum_next, row_sum_next, hit_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbc_pkg::FRAME_WIDTH_RESET;
      frame_height <= bbc_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bbc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bbc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      column_sum   <= '0;
      row_sum      <= '0;
      hit_count    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        column_sum   <= '0;
        row_sum      <= '0;
        hit_count    <= '0;
      end else begin
        column_sum <= column_sum_next;
        row_sum    <= row_sum_next;
        hit_count  <= hit_count_next;
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/bbc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_queue
// Small register queue of frame totals between the pixel side and the
// divider.
// ----------------------------------------------------------------------------
module bbc_queue #(
  parameter int ENTRY_W = 8,
  parameter int DEPTH   = bbc_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [ENTRY_W-1:0] push_data,
  input  wire logic               pop,
  output logic [ENTRY_W-1:0]      pop_data,
  output logic                    full,
  output logic                    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full     = (32'(fill) == 32'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/bbc_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_divider
// Back end: pops frame totals, runs two restoring dividers one quotient bit
// per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bbc_divider #(
  parameter int HIT_W = 21,
  parameter int SUM_W = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  input  wire logic [2*SUM_W+HIT_W-1:0]       q_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bbc_pkg::COORD_W-1:0]         center_x,
  output logic [bbc_pkg::COORD_W-1:0]         center_y,
  output logic                                found
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t           state;
  logic [SUM_W-1:0] num_x;
  logic [SUM_W-1:0] num_y;
  logic [HIT_W-1:0] rem_x;
  logic [HIT_W-1:0] rem_y;
  logic [HIT_W-1:0] divisor;
  logic [STEP_W-1:0] step;

  logic [HIT_W:0]   trial_x;
  logic [HIT_W:0]   trial_y;
  logic             ge_x;
  logic             ge_y;
  logic [HIT_W:0]   rem_x_next;
  logic [HIT_W:0]   rem_y_next;
  logic             out_free;
  logic             has_hits;

  always_comb begin
    trial_x    = {rem_x, num_x[SUM_W-1]};
    trial_y    = {rem_y, num_y[SUM_W-1]};
    ge_x       = (trial_x >= {1'b0, divisor});
    ge_y       = (trial_y >= {1'b0, divisor});
    rem_x_next = ge_x ? (trial_x - {1'b0, divisor}) : trial_x;
    rem_y_next = ge_y ? (trial_y - {1'b0, divisor}) : trial_y;
    has_hits   = (divisor != '0);
  end

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // Drop a taken result; HOLD reloads the register on its own.
      if (out_valid && !out_stall && state != ST_HOLD) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            num_x   <= q_data[2*SUM_W+HIT_W-1 -: SUM_W];
            num_y   <= q_data[SUM_W+HIT_W-1 -: SUM_W];
            divisor <= q_data[HIT_W-1:0];
            rem_x   <= '0;
            rem_y   <= '0;
            step    <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Shift quotient bits into the dividend register as it drains.
          rem_x <= rem_x_next[HIT_W-1:0];
          rem_y <= rem_y_next[HIT_W-1:0];
          num_x <= {num_x[SUM_W-2:0], ge_x};
          num_y <= {num_y[SUM_W-2:0], ge_y};
          step  <= step + STEP_W'(1);
          if (32'(step) == SUM_W - 1) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            center_x  <= has_hits ? bbc_pkg::COORD_W'(num_x) : '0;
            center_y  <= has_hits ? bbc_pkg::COORD_W'(num_y) : '0;
            found     <= has_hits;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/binary_blob_centroid.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_blob_centroid
// Centroid of the non-background (not 255) pixels of a raster-order frame.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while the input is not stalled, in raster
// order, with no gaps needed between frames. Column and row are tracked
// internally from frame_width and frame_height (register 0 and 1; zero acts
// as one, larger than the limit saturates). A size change applies at once,
// so write it between frames. After the last pixel of a frame the totals go
// into a two-entry queue, and a back end divides both sums by the hit count
// with restoring dividers that produce one quotient bit per clock. One
// result follows each frame. SUM_W is the coordinate width plus the hit
// counter width (31 at the default 1024 x 1024 limits). The pixel input
// stalls only while both queue entries are taken, so short frames are paced
// by the divider, which takes the next frame's totals only once it has
// finished the last. An empty frame gives zero coordinates with found clear.
// ----------------------------------------------------------------------------
module binary_blob_centroid #(
  parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]       cfg_data,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bbc_pkg::PIXEL_W-1:0]     pixel_value,
  // centroid output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bbc_pkg::COORD_W-1:0]          center_x,
  output logic [bbc_pkg::COORD_W-1:0]          center_y,
  output logic                                 found
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int HIT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUM_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + HIT_W;
  localparam int ENTRY_W = 2 * SUM_W + HIT_W;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_push_data;
  logic [ENTRY_W-1:0] q_pop_data;

  // Registers are always writable; the user must keep the block idle whenever they change, as the block does not check.
  assign cfg_ready = 1'b1;

  bbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W),
    .HIT_W      (HIT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  // Hold finished frame totals until the divider is free.
  bbc_queue #(
    .ENTRY_W (ENTRY_W),
    .DEPTH   (bbc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bbc_divider #(
    .HIT_W (HIT_W),
    .SUM_W (SUM_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .center_x  (center_x),
    .center_y  (center_y),
    .found     (found)
  );

  // Never push a frame request into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame request pushed into full queue");

  // Never pop a request from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("divider popped empty queue");

  // An empty frame reports zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (center_x == '0 && center_y == '0))
    else $error("empty frame result with nonzero coordinates");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_blob_centroid: streams grey frames, predicts
// the centroid of each frame and compares it with every result that leaves
// the block.
// ----------------------------------------------------------------------------
// A table of short frames comes first: empty frames, a one-pixel frame, zero
// size registers and a size change in the middle of a frame. Random frames
// follow: one at the largest width, a run of one-pixel frames while the
// output is held off so the input has to stall, and then many small frames
// of random size and content.
// ----------------------------------------------------------------------------
module tb_top;
  import bbc_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int SETTLE       = 64;       // lets the divider finish its last frame
  localparam int LONG_HOLD    = 400;
  localparam int SMALL_PIXELS = 750;
  localparam int REPORT_MAX   = 10;
  localparam int DIRECTED_ROWS = 29;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               found;
  } centroid_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_W-1:0]        data;
    logic [PIXEL_W-1:0]      pix;
    bit                      typed;
    centroid_t               want;
  } row_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam centroid_t NO_HIT = '{x: '0, y: '0, found: 1'b0};

  // Rows marked typed carry a centroid that can be read off by hand; the
  // others are checked against the predictor.
  row_t directed_rows [DIRECTED_ROWS] = '{
    // zero size registers act as one: every pixel is a whole frame
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b1, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b1, '{10'd0, 10'd0, 1'b1}},
    // 3 x 2 frame with hits on both rows
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd3, 8'd0,   1'b0, NO_HIT},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd2, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd254, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd128, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd1,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    // 2 x 2: empty frame, then a single hit in the last corner
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd2, 8'd0,   1'b0, NO_HIT},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd2, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b1, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd255, 1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b1, '{10'd1, 10'd1, 1'b1}},
    // shrink the width while three columns of a 4 x 1 row are in: the
    // position already passed the new last column, so the next pixel ends it
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd4, 8'd0,   1'b0, NO_HIT},
    '{ROW_CFG, REG_FRAME_HEIGHT, 11'd1, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b0, NO_HIT},
    '{ROW_CFG, REG_FRAME_WIDTH,  11'd2, 8'd0,   1'b0, NO_HIT},
    '{ROW_PIX, REG_FRAME_WIDTH,  11'd0, 8'd0,   1'b1, '{10'd1, 10'd0, 1'b1}}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIXEL_W-1:0]     pixel_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [COORD_W-1:0]     center_x;
  logic [COORD_W-1:0]     center_y;
  logic                   found;

  // Predictor state: register copies and the running frame totals.
  logic [CFG_W-1:0]   width_reg  = FRAME_WIDTH_RESET;
  logic [CFG_W-1:0]   height_reg = FRAME_HEIGHT_RESET;
  logic [COORD_W-1:0] col_pos    = '0;
  logic [COORD_W-1:0] row_pos    = '0;
  logic [29:0]        col_sum    = '0;
  logic [29:0]        row_sum    = '0;
  logic [20:0]        hit_total  = '0;

  centroid_t centroids_due [$];
  int        mismatches = 0;

  // Sender controls used by the stimulus tasks, the checker and the receiver.
  bit        want_typed = 1'b0;
  centroid_t typed_centroid = NO_HIT;
  bit        steady_sender = 1'b0;
  bit        pressure_on = 1'b0;
  int        burst_left = 0;

  binary_blob_centroid dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .center_x    (center_x),
    .center_y    (center_y),
    .found       (found)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(20 * 1000000);
    $display("TB_ERROR");
    $finish;
  end

  // A register value of zero means one; anything past the limit saturates.
  function automatic int eff_size(input logic [CFG_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Advance the raster position by one pixel and close the frame when the
  // position reaches or passes the last column of the last row.
  task automatic track_pixel(input logic [PIXEL_W-1:0] pix, output bit done,
                             output centroid_t c);
    int          w;
    int          h;
    logic [29:0] quot;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    done = 1'b0;
    c = NO_HIT;
    if (pix != BACKGROUND) begin
      col_sum   += 30'(col_pos);
      row_sum   += 30'(row_pos);
      hit_total += 21'd1;
    end
    if (int'(col_pos) + 1 < w) begin
      col_pos += 1'b1;
      return;
    end
    col_pos = '0;
    if (int'(row_pos) + 1 < h) begin
      row_pos += 1'b1;
      return;
    end
    if (hit_total != '0) begin
      quot = col_sum / 30'(hit_total);
      c.x = quot[COORD_W-1:0];
      quot = row_sum / 30'(hit_total);
      c.y = quot[COORD_W-1:0];
      c.found = 1'b1;
    end
    done = 1'b1;
    row_pos = '0;
    col_sum = '0;
    row_sum = '0;
    hit_total = '0;
  endtask

  task automatic note_mismatch(input string what, input centroid_t want,
                               input centroid_t got);
    if (mismatches < REPORT_MAX)
      $display("centroid mismatch (%s): expected x=%0d y=%0d found=%0d, got x=%0d y=%0d found=%0d",
               what, want.x, want.y, want.found, got.x, got.y, got.found);
    mismatches++;
  endtask

  // Checker: track register writes and accepted pixels, compare each
  // accepted centroid with the oldest one due.
  always @(posedge clk) begin
    bit        done;
    centroid_t c;
    centroid_t got;
    if (!rst) begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got = '{x: center_x, y: center_y, found: found};
        if (centroids_due.size() == 0) begin
          note_mismatch("nothing due", NO_HIT, got);
        end else begin
          c = centroids_due.pop_front();
          if (got.x !== c.x || got.y !== c.y || got.found !== c.found)
            note_mismatch("wrong field", c, got);
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        track_pixel(pixel_value, done, c);
        if (done) centroids_due.push_back(want_typed ? typed_centroid : c);
      end
    end
  end

  // Receiver: stall on a pattern picked at random from four that changes at random
  // intervals, and hold off once for a long stretch when the pressure phase starts.
  initial begin
    stall_mode_t mode;
    int          mode_left;
    bit          held;
    out_stall = 1'b0;
    mode = STALL_NONE;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (mode)
        STALL_NONE:     out_stall = 1'b0;
        STALL_RANDOM:   out_stall = ($urandom_range(0, 1) == 0);
        STALL_HEAVY:    out_stall = ($urandom_range(0, 4) != 0);
        STALL_PERIODIC: out_stall = ((mode_left % 7) < 3);
        default:        out_stall = 1'b0;
      endcase
    end
  end

  // Offer one pixel and hold it until it is taken. Called and returns at a
  // falling edge; valid stays high into the next request of the burst.
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit typed,
                            input centroid_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady_sender && $urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    pixel_value = pix;
    want_typed = typed;
    typed_centroid = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, wait for every due centroid, then let the divider settle.
  task automatic drain();
    in_valid = 1'b0;
    want_typed = 1'b0;
    while (centroids_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // One frame: hits in a random window at a random density, plus sparse
  // noise on small frames. Large frames put their hits in the last few
  // positions to drive the centroid near its top value.
  task automatic send_frame(input int npix);
    int lo;
    int hi;
    int pct;
    bit noise;
    bit hit;
    lo = $urandom_range(0, npix - 1);
    hi = $urandom_range(lo, npix - 1);
    pct = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 100);
    noise = (npix <= 64);
    if (!noise) begin
      hi = npix - 1;
      lo = hi - $urandom_range(0, 3);
      pct = 100;
    end
    for (int k = 0; k < npix; k++) begin
      hit = (k >= lo && k <= hi && $urandom_range(1, 100) <= pct) ||
            (noise && $urandom_range(0, 49) == 0);
      send_pixel(hit ? PIXEL_W'($urandom_range(0, 254)) : BACKGROUND, 1'b0, NO_HIT);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int frames);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    repeat (frames) send_frame(eff_size(w, MAX_W) * eff_size(h, MAX_H));
  endtask

  initial begin
    int               small_pixels;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    int               frames;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_value = '0;
    small_pixels = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the table; registers change only once the block is quiet.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Widest frame, through a saturating register value.
    run_phase(11'd2047, 11'd1, 1);

    // One-pixel frames back to back while the output is held off; start
    // the hold only once the sender is ready to keep offering.
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    steady_sender = 1'b1;
    pressure_on = 1'b1;
    repeat (60) send_frame(1);
    steady_sender = 1'b0;

    while (small_pixels < SMALL_PIXELS) begin
      w = ($urandom_range(0, 7) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 6));
      h = ($urandom_range(0, 7) == 0) ? 11'd0 : CFG_W'($urandom_range(1, 4));
      frames = $urandom_range(2, 8);
      run_phase(w, h, frames);
      small_pixels += frames * eff_size(w, MAX_W) * eff_size(h, MAX_H);
    end

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
